FILE: sv/bpa_pkg.sv
// Shared constants, codes and helpers for the bitmap page allocator.
package bpa_pkg;

    localparam int MAX_PAGES = 4096;
    localparam int PAGE_W    = $clog2(MAX_PAGES);
    localparam int COUNT_W   = PAGE_W + 1;
    localparam int MAP_BITS  = 64;
    localparam int BIT_W     = $clog2(MAP_BITS);
    localparam int MAP_WORDS = MAX_PAGES / MAP_BITS;
    localparam int WORD_AW   = $clog2(MAP_WORDS);

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int IN_W     = 16;
    localparam int OUT_W    = 32;

    typedef logic [MAP_BITS-1:0] map_word_t;
    typedef logic [WORD_AW-1:0]  word_addr_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_CHECK = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXTEND,
        S_LOOKUP
    } state_t;

    // index of the lowest clear bit (0 if none); its result is used only on a word that has one
    function automatic logic [BIT_W-1:0] first_zero(input map_word_t word);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = MAP_BITS - 1; i >= 0; i--) begin
            if (!word[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

FILE: sv/bpa_bitmap_ram.sv
// Allocation bitmap RAM: registered read, per-row valid flags give the reset image.
module bpa_bitmap_ram
    import bpa_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  word_addr_t rd_addr,
    output map_word_t  rd_data,
    input  logic       wr_en,
    input  word_addr_t wr_addr,
    input  map_word_t  wr_data
);

    map_word_t              mem [MAP_WORDS];
    logic [MAP_WORDS-1:0]   row_valid_reg;
    map_word_t              rd_word_reg;
    logic                   rd_fresh_reg;
    logic                   rd_row0_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_word_reg  <= mem[rd_addr];
        rd_fresh_reg <= row_valid_reg[rd_addr];
        rd_row0_reg  <= (rd_addr == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
        end else if (wr_en) begin
            row_valid_reg[wr_addr] <= 1'b1;
        end
    end

    // untouched rows read as reset: header page bit set in row 0 only
    assign rd_data = rd_fresh_reg ? rd_word_reg
                   : (rd_row0_reg ? map_word_t'(1) : '0);

endmodule

FILE: sv/bitmap_page_allocator_unit.sv
// Bitmap page allocator top level: request decode, bitmap scan and result register.
// Allocate when full and an unknown command load the result from the request;
//   free, check and allocate that extends the file pass through the lookup or
//   extend state; allocate that reuses a page scans words up to one with a clear bit.
// One request at a time, taken in idle once the result register is empty or being read;
//   the scan reads one 64-bit bitmap word per cycle through the RAM's single read port.
// Reset (aresetn low, synchronous) sets page 0 allocated and both counts to 1,
//   through per-row valid flags in the RAM; no clearing pass is needed.
module bitmap_page_allocator_unit
    import bpa_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // [1:0] command, [13:2] page_number
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // [11:0] result_page, [13:12] status,
                                        // [26:14] allocated_count
);

    state_t             state_reg, state_next;
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [PAGE_W-1:0]  page_reg, page_next;
    word_addr_t         scan_addr_reg, scan_addr_next;
    logic [COUNT_W-1:0] hwm_reg, hwm_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [PAGE_W-1:0]  res_page_reg, res_page_next;
    status_t            status_reg, status_next;
    logic [COUNT_W-1:0] res_count_reg, res_count_next;

    word_addr_t         rd_addr;
    map_word_t          rd_data;
    logic               wr_en;
    word_addr_t         wr_addr;
    map_word_t          wr_data;

    logic               accept;
    logic [CMD_W-1:0]   in_cmd;
    logic [PAGE_W-1:0]  in_page;
    logic [BIT_W-1:0]   zero_idx;
    logic               page_ok;

    assign in_cmd   = s_tdata[CMD_W-1:0];
    assign in_page  = s_tdata[CMD_W+PAGE_W-1:CMD_W];
    assign s_tready = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign zero_idx = first_zero(rd_data);
    assign page_ok  = ({1'b0, page_reg} < hwm_reg) && rd_data[page_reg[BIT_W-1:0]];

    bpa_bitmap_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (in_cmd)
                        CMD_ALLOC: begin
                            if (count_reg < hwm_reg) begin
                                state_next = S_SCAN;
                            end else if (hwm_reg < COUNT_W'(MAX_PAGES)) begin
                                state_next = S_EXTEND;
                            end
                        end
                        CMD_FREE, CMD_CHECK: state_next = S_LOOKUP;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (~rd_data != '0) begin
                    state_next = S_IDLE;
                end
            end
            S_EXTEND: state_next = S_IDLE;
            S_LOOKUP: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        cmd_next       = cmd_reg;
        page_next      = page_reg;
        scan_addr_next = scan_addr_reg;
        hwm_next       = hwm_reg;
        count_next     = count_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        res_page_next  = res_page_reg;
        status_next    = status_reg;
        res_count_next = res_count_reg;
        rd_addr        = scan_addr_reg;
        wr_en          = 1'b0;
        wr_addr        = scan_addr_reg;
        wr_data        = rd_data;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd_next  = in_cmd;
                    page_next = in_page;
                    case (in_cmd)
                        CMD_ALLOC: begin
                            if (count_reg < hwm_reg) begin
                                rd_addr        = '0;
                                scan_addr_next = '0;
                            end else if (hwm_reg < COUNT_W'(MAX_PAGES)) begin
                                rd_addr = hwm_reg[PAGE_W-1:BIT_W];
                            end else begin
                                m_tvalid_next  = 1'b1;
                                res_page_next  = in_page;
                                status_next    = ST_FULL;
                                res_count_next = count_reg;
                            end
                        end
                        CMD_FREE, CMD_CHECK: begin
                            rd_addr = in_page[PAGE_W-1:BIT_W];
                        end
                        default: begin
                            m_tvalid_next  = 1'b1;
                            res_page_next  = in_page;
                            status_next    = ST_INVALID;
                            res_count_next = count_reg;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (~rd_data != '0) begin
                    wr_en          = 1'b1;
                    wr_addr        = scan_addr_reg;
                    wr_data        = rd_data | (map_word_t'(1) << zero_idx);
                    count_next     = count_reg + 1'b1;
                    m_tvalid_next  = 1'b1;
                    res_page_next  = {scan_addr_reg, zero_idx};
                    status_next    = ST_OK;
                    res_count_next = count_reg + 1'b1;
                end else begin
                    scan_addr_next = scan_addr_reg + 1'b1;
                    rd_addr        = scan_addr_reg + 1'b1;
                end
            end
            S_EXTEND: begin
                wr_en          = 1'b1;
                wr_addr        = hwm_reg[PAGE_W-1:BIT_W];
                wr_data        = rd_data | (map_word_t'(1) << hwm_reg[BIT_W-1:0]);
                hwm_next       = hwm_reg + 1'b1;
                count_next     = count_reg + 1'b1;
                m_tvalid_next  = 1'b1;
                res_page_next  = hwm_reg[PAGE_W-1:0];
                status_next    = ST_OK;
                res_count_next = count_reg + 1'b1;
            end
            S_LOOKUP: begin
                m_tvalid_next  = 1'b1;
                res_page_next  = page_reg;
                status_next    = page_ok ? ST_OK : ST_INVALID;
                res_count_next = count_reg;
                if (cmd_reg == CMD_FREE && page_ok) begin
                    wr_en   = 1'b1;
                    wr_addr = page_reg[PAGE_W-1:BIT_W];
                    wr_data = rd_data & ~(map_word_t'(1) << page_reg[BIT_W-1:0]);
                    if (count_reg != '0) begin
                        count_next     = count_reg - 1'b1;
                        res_count_next = count_reg - 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            hwm_reg      <= COUNT_W'(1);
            count_reg    <= COUNT_W'(1);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            hwm_reg      <= hwm_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        page_reg      <= page_next;
        scan_addr_reg <= scan_addr_next;
        res_page_reg  <= res_page_next;
        status_reg    <= status_next;
        res_count_reg <= res_count_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(OUT_W - PAGE_W - STATUS_W - COUNT_W)'(0),
                       res_count_reg, status_reg, res_page_reg};

`ifndef SYNTH
    a_count_below_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= hwm_reg)
        else $error("allocated count above high-water mark");

    a_mark_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (hwm_reg != '0) && (hwm_reg <= COUNT_W'(MAX_PAGES)))
        else $error("high-water mark out of range");

    a_mark_steps_by_one: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && hwm_reg != $past(hwm_reg))
            |-> (hwm_reg == $past(hwm_reg) + 1'b1) && $past(state_reg == S_EXTEND))
        else $error("high-water mark moved outside an extend");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> m_tvalid_reg && $stable(m_tdata))
        else $error("waiting result lost or changed");

    a_scan_finds_hole: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && ~rd_data != '0)
            |-> ({scan_addr_reg, zero_idx} < hwm_reg[PAGE_W-1:0]) || hwm_reg[PAGE_W])
        else $error("reused page at or above high-water mark");
`endif

endmodule
